/* rtl/core/mces_pkg.sv */
// Package of shared constants for the monotone chain envelope search core.
package mces_pkg;

  // Default values of the top-level parameters.
  localparam int DefMaxPoints  = 64;
  localparam int DefCoordBits  = 32;
  localparam int DefStackDepth = 8;

  // Fixed field widths.
  localparam int IdxW  = 6;
  localparam int CntW  = 6;
  localparam int OutW  = 8;
  localparam int CfgDW = 6;

  // Most results a single query may return.
  localparam logic [CntW-1:0] ResCap = 6'd63;

  // Configuration register indexes.
  localparam logic REG_CHAIN_START = 1'b0;
  localparam logic REG_CHAIN_END   = 1'b1;

  // Register reset values.
  localparam logic [CfgDW-1:0] ChainStartRst = 6'd0;
  localparam logic [CfgDW-1:0] ChainEndRst   = 6'd1;

endpackage

/* rtl/core/mces_axis.sv */
// Shared single-axis overlap test between a segment span and the search interval.
module mces_axis import mces_pkg::*; #(
  parameter int W = DefCoordBits
) (
  input  logic signed [W-1:0] p_i,
  input  logic signed [W-1:0] q_i,
  input  logic signed [W-1:0] lo_i,
  input  logic signed [W-1:0] hi_i,
  output logic                hit_o
);

  logic signed [W-1:0] span_min;
  logic signed [W-1:0] span_max;

  // Order the two end points, then check that the intervals touch or overlap.
  assign span_min = (p_i < q_i) ? p_i : q_i;
  assign span_max = (p_i < q_i) ? q_i : p_i;
  assign hit_o    = !((lo_i > span_max) || (hi_i < span_min));

endmodule

/* rtl/core/monotone_chain_envelope_select_core.sv */
// Top level of the monotone chain envelope search core.
//
//  Channel   Dir  Handshake              Contents
//  s_axis    in   tvalid/tready          tuser: req_type; tdata: point and box fields
//  m_axis    out  tvalid/tready/tlast    tuser: segment_valid; tdata: segment_index
//  cfg       in   cfg_we_i (no wait)     cfg_idx_i selects chain_start or chain_end
//
// A load word is written to the point store as soon as it is taken.
// A query word is taken, then ranges are popped off the range stack; each range
// that needs a box test is checked on x and then on y through the single shared
// axis comparator, after a registered store read. Each selected segment has a
// step of its own; the pop that finds the stack empty and a closing step end
// the answer. Output stalls can hold the segment and closing steps.
// Input is refused from the moment a query is taken until its last word has
// been placed in the output register; that register parts the output side, so
// a new word may be taken while the final result still waits to be read.
// Reset is asynchronous and active low; it clears control state and the two
// chain registers, while the point store and the range stack hold no reset.
module monotone_chain_envelope_select_core import mces_pkg::*; #(
  parameter  int MAX_POINTS  = DefMaxPoints,
  parameter  int COORD_BITS  = DefCoordBits,
  parameter  int STACK_DEPTH = DefStackDepth,
  localparam int InW         = ((IdxW + 6 * COORD_BITS + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // Input stream.
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // Fields from bit 0 up: point_index, point_x, point_y, query_min_x,
  // query_max_x, query_min_y, query_max_y, zero padding.
  input  logic [InW-1:0]   s_axis_tdata,
  // Fields from bit 0 up: req_type.
  input  logic             s_axis_tuser,
  // Output stream.
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // Fields from bit 0 up: segment_index, zero padding.
  output logic [OutW-1:0]  m_axis_tdata,
  // Fields from bit 0 up: segment_valid.
  output logic             m_axis_tuser,
  output logic             m_axis_tlast,
  // Configuration write port.
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CfgDW-1:0] cfg_data_i
);

  localparam int AW  = $clog2(MAX_POINTS);
  localparam int SIW = $clog2(STACK_DEPTH);
  localparam int SLW = $clog2(STACK_DEPTH + 1);

  // Sequencer states.
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_POP  = 6'b000010,
    ST_TX   = 6'b000100,
    ST_TY   = 6'b001000,
    ST_SEG  = 6'b010000,
    ST_FIN  = 6'b100000
  } state_e;

  // One entry of the range stack: start and end point index.
  typedef struct packed {
    logic [IdxW-1:0] a;
    logic [IdxW-1:0] b;
  } range_t;

  // Input word fields.
  logic        [IdxW-1:0]       in_idx;
  logic signed [COORD_BITS-1:0] in_px, in_py, in_qx0, in_qx1, in_qy0, in_qy1;
  logic                         in_req;

  assign in_req = s_axis_tuser;
  assign in_idx = s_axis_tdata[IdxW-1:0];
  assign in_px  = s_axis_tdata[IdxW                  +: COORD_BITS];
  assign in_py  = s_axis_tdata[IdxW +     COORD_BITS +: COORD_BITS];
  assign in_qx0 = s_axis_tdata[IdxW + 2 * COORD_BITS +: COORD_BITS];
  assign in_qx1 = s_axis_tdata[IdxW + 3 * COORD_BITS +: COORD_BITS];
  assign in_qy0 = s_axis_tdata[IdxW + 4 * COORD_BITS +: COORD_BITS];
  assign in_qy1 = s_axis_tdata[IdxW + 5 * COORD_BITS +: COORD_BITS];

  // Control registers.
  state_e           state_q, state_d;
  logic [CfgDW-1:0] chain_start_q, chain_end_q;
  logic [SLW-1:0]   level_q, level_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             pend_valid_q, pend_valid_d;
  logic             out_valid_q, out_valid_d;

  // Payload registers.
  logic signed [COORD_BITS-1:0] qx0_q, qx1_q, qy0_q, qy1_q;
  logic                         box_empty_q, box_empty_d;
  logic        [IdxW-1:0]       cur_a_q, cur_a_d, cur_b_q, cur_b_d;
  logic                         hit_x_q, hit_x_d;
  logic        [IdxW-1:0]       pend_idx_q, pend_idx_d;
  logic        [IdxW-1:0]       out_idx_q, out_idx_d;
  logic                         out_seg_q, out_seg_d;
  logic                         out_last_q, out_last_d;

  // Point store and range stack.
  logic signed [COORD_BITS-1:0] x_mem [MAX_POINTS];
  logic signed [COORD_BITS-1:0] y_mem [MAX_POINTS];
  logic signed [COORD_BITS-1:0] xa_q, xb_q, ya_q, yb_q;
  range_t                       stack_q [STACK_DEPTH];

  // Handshakes.
  logic in_fire, out_free;
  assign s_axis_tready = state_q == ST_IDLE;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  // Chain bounds, saturated to the store.
  logic [IdxW-1:0] sat_start, sat_end;
  assign sat_start = (32'(chain_start_q) > MAX_POINTS - 1) ? IdxW'(MAX_POINTS - 1)
                                                           : chain_start_q;
  assign sat_end   = (32'(chain_end_q) > MAX_POINTS - 1) ? IdxW'(MAX_POINTS - 1)
                                                         : chain_end_q;

  // Top of the range stack and the store read addresses taken from it.
  range_t          top;
  logic [IdxW:0]   mid_sum;
  logic [IdxW-1:0] mid;
  assign top     = stack_q[SIW'(level_q - 1'b1)];
  assign mid_sum = {1'b0, cur_a_q} + {1'b0, cur_b_q};
  assign mid     = mid_sum[IdxW:1];

  // The one axis comparator, fed with x in one cycle and y in the next.
  logic signed [COORD_BITS-1:0] ax_p, ax_q, ax_lo, ax_hi;
  logic                         ax_hit;
  logic                         test_y;
  assign test_y = state_q == ST_TY;
  assign ax_p   = test_y ? ya_q  : xa_q;
  assign ax_q   = test_y ? yb_q  : xb_q;
  assign ax_lo  = test_y ? qy0_q : qx0_q;
  assign ax_hi  = test_y ? qy1_q : qx1_q;

  mces_axis #(
    .W (COORD_BITS)
  ) u_axis (
    .p_i   (ax_p),
    .q_i   (ax_q),
    .lo_i  (ax_lo),
    .hi_i  (ax_hi),
    .hit_o (ax_hit)
  );

  // Stack write strobes.
  logic load_we, init_push, push_hi, push_lo;

  always_comb begin
    state_d      = state_q;
    level_d      = level_q;
    count_d      = count_q;
    pend_valid_d = pend_valid_q;
    pend_idx_d   = pend_idx_q;
    box_empty_d  = box_empty_q;
    cur_a_d      = cur_a_q;
    cur_b_d      = cur_b_q;
    hit_x_d      = hit_x_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_idx_d    = out_idx_q;
    out_seg_d    = out_seg_q;
    out_last_d   = out_last_q;
    load_we      = 1'b0;
    init_push    = 1'b0;
    push_hi      = 1'b0;
    push_lo      = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (!in_req) begin
            load_we = 32'(in_idx) < MAX_POINTS;
          end else begin
            box_empty_d = (in_qx0 > in_qx1) || (in_qy0 > in_qy1);
            init_push   = sat_start < sat_end;
            level_d     = init_push ? SLW'(1) : '0;
            count_d     = '0;
            state_d     = ST_POP;
          end
        end
      end
      ST_POP: begin
        if (level_q == '0 || count_q == ResCap) begin
          state_d = ST_FIN;
        end else begin
          level_d = level_q - 1'b1;
          cur_a_d = top.a;
          cur_b_d = top.b;
          if (top.a >= top.b) begin
            state_d = ST_POP;
          end else if (top.b - top.a == IdxW'(1)) begin
            state_d = ST_SEG;
          end else if (box_empty_q) begin
            state_d = ST_POP;
          end else begin
            state_d = ST_TX;
          end
        end
      end
      ST_TX: begin
        hit_x_d = ax_hit;
        state_d = ST_TY;
      end
      ST_TY: begin
        if (hit_x_q && ax_hit) begin
          // Upper half goes in first so the lower half is searched first.
          push_hi = level_q < SLW'(STACK_DEPTH);
          push_lo = level_q < SLW'(STACK_DEPTH - 1);
          level_d = level_q + SLW'(push_hi) + SLW'(push_lo);
        end
        state_d = ST_POP;
      end
      ST_SEG: begin
        // A found segment is held back until the next one shows whether it is last.
        if (!pend_valid_q) begin
          pend_valid_d = 1'b1;
          pend_idx_d   = cur_a_q;
          count_d      = count_q + 1'b1;
          state_d      = ST_POP;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_idx_d   = pend_idx_q;
          out_seg_d   = 1'b1;
          out_last_d  = 1'b0;
          pend_idx_d  = cur_a_q;
          count_d     = count_q + 1'b1;
          state_d     = ST_POP;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_idx_d    = pend_valid_q ? pend_idx_q : '0;
          out_seg_d    = pend_valid_q;
          out_last_d   = 1'b1;
          pend_valid_d = 1'b0;
          count_d      = '0;
          level_d      = '0;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      chain_start_q <= ChainStartRst;
      chain_end_q   <= ChainEndRst;
      level_q       <= '0;
      count_q       <= '0;
      pend_valid_q  <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      level_q      <= level_d;
      count_q      <= count_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_CHAIN_START: chain_start_q <= cfg_data_i;
          REG_CHAIN_END:   chain_end_q   <= cfg_data_i;
          default:         chain_end_q   <= chain_end_q;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    box_empty_q <= box_empty_d;
    cur_a_q     <= cur_a_d;
    cur_b_q     <= cur_b_d;
    hit_x_q     <= hit_x_d;
    pend_idx_q  <= pend_idx_d;
    out_idx_q   <= out_idx_d;
    out_seg_q   <= out_seg_d;
    out_last_q  <= out_last_d;
    if (in_fire && in_req) begin
      qx0_q <= in_qx0;
      qx1_q <= in_qx1;
      qy0_q <= in_qy0;
      qy1_q <= in_qy1;
    end
  end

  // Point store: one write port, two registered read ports per axis. The read
  // registers are loaded only on a pop, so they hold the popped range's end
  // points through both axis tests.
  always_ff @(posedge clk_i) begin
    if (load_we) begin
      x_mem[AW'(in_idx)] <= in_px;
      y_mem[AW'(in_idx)] <= in_py;
    end
    if (state_q == ST_POP) begin
      xa_q <= x_mem[AW'(top.a)];
      xb_q <= x_mem[AW'(top.b)];
      ya_q <= y_mem[AW'(top.a)];
      yb_q <= y_mem[AW'(top.b)];
    end
  end

  // Range stack.
  always_ff @(posedge clk_i) begin
    if (init_push) begin
      stack_q[0] <= '{a: sat_start, b: sat_end};
    end
    if (push_hi) begin
      stack_q[SIW'(level_q)] <= '{a: mid, b: cur_b_q};
    end
    if (push_lo) begin
      stack_q[SIW'(level_q + 1'b1)] <= '{a: cur_a_q, b: mid};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutW'(out_idx_q);
  assign m_axis_tuser  = out_seg_q;
  assign m_axis_tlast  = out_last_q;

endmodule

/* rtl/core/mces_chk.sv */
// Port-level checker for the monotone chain envelope search core, with its bind.
module mces_chk import mces_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            s_axis_tvalid,
  input logic            s_axis_tready,
  input logic            s_axis_tuser,
  input logic            m_axis_tvalid,
  input logic            m_axis_tready,
  input logic [OutW-1:0] m_axis_tdata,
  input logic            m_axis_tuser,
  input logic            m_axis_tlast
);

  // A result word that is not taken stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                        && $stable(m_axis_tlast))
    else $error("stalled result word changed");

  // The empty answer is always the closing word of its query.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && m_axis_tdata == '0)
    else $error("empty answer not final or not zero");

  // A load word leaves the block ready for the next word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> s_axis_tready)
    else $error("block busy after a load");

  // A query word makes the block busy while the search runs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
    else $error("block ready straight after a query");

endmodule

bind monotone_chain_envelope_select_core mces_chk u_mces_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

/* tb/tb_monotone_chain_envelope_select_core.sv */
// Self-checking testbench for the monotone chain envelope search core.
module tb_monotone_chain_envelope_select_core;
  import mces_pkg::*;

  localparam int InW   = ((IdxW + 6 * DefCoordBits + 7) / 8) * 8;
  localparam int PadW  = InW - IdxW - 6 * DefCoordBits;
  localparam int NumRandomWords = 112;

  // The kind of an input word travels on tuser.
  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_QUERY = 1'b1
  } req_kind_e;

  typedef logic signed [DefCoordBits-1:0] coord_t;

  localparam coord_t CoordMin = {1'b1, {(DefCoordBits - 1){1'b0}}};
  localparam coord_t CoordMax = {1'b0, {(DefCoordBits - 1){1'b1}}};
  // One unit in Q16.16.
  localparam int Unit = 32'h0001_0000;

  typedef struct packed {
    req_kind_e        kind;
    logic [IdxW-1:0]  slot;
    coord_t           px;
    coord_t           py;
    coord_t           qx0;
    coord_t           qx1;
    coord_t           qy0;
    coord_t           qy1;
  } req_word_t;

  typedef struct packed {
    logic [IdxW-1:0] seg;
    logic            vld;
    logic            lst;
  } seg_word_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [InW-1:0]   s_axis_tdata = '0;
  logic             s_axis_tuser = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OutW-1:0]  m_axis_tdata;
  logic             m_axis_tuser;
  logic             m_axis_tlast;
  logic             cfg_we_i = 1'b0;
  logic             cfg_idx_i = REG_CHAIN_START;
  logic [CfgDW-1:0] cfg_data_i = '0;

  monotone_chain_envelope_select_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the point store, the two chain registers
  // and the range stack that the bisection walk uses.
  // ---------------------------------------------------------------------------
  coord_t          pt_x [DefMaxPoints];
  coord_t          pt_y [DefMaxPoints];
  logic [IdxW-1:0] chain_start_q = ChainStartRst;
  logic [IdxW-1:0] chain_end_q   = ChainEndRst;
  int              range_lo [DefStackDepth];
  int              range_hi [DefStackDepth];
  int              range_level;

  seg_word_t expected_segs [$];
  req_word_t pending_words [$];

  // Generator view of the store, so that a query never reads a slot that was
  // never loaded since reset.
  coord_t          gen_x [DefMaxPoints];
  coord_t          gen_y [DefMaxPoints];
  bit              gen_written [DefMaxPoints];
  int              gen_cs = ChainStartRst;
  int              gen_ce = ChainEndRst;

  int  err_count    = 0;
  int  words_left   = 0;
  int  words_queued = 0;
  int  loads_sent   = 0;
  int  queries_sent = 0;
  int  chain_settings = 1;
  int  results_seen = 0;
  int  longest_answer = 0;
  bit  no_gaps      = 1'b0;

  // Handshake bookkeeping shared between the sampling and driving blocks.
  req_word_t cur_word;
  bit        word_taken = 1'b0;
  int        send_gap   = 0;
  bit        seg_taken  = 1'b0;
  int        ready_gap  = 3;
  seg_word_t want_seg;

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    if (err_count < 100)
      $display("MISMATCH at %0t: %s: got %0d, expected %0d", $time, what, got, want);
    err_count++;
  endtask

  function automatic void push_range(input int lo, input int hi);
    // A push onto a full stack is silently dropped, as the block does.
    if (range_level < DefStackDepth) begin
      range_lo[range_level] = lo;
      range_hi[range_level] = hi;
      range_level++;
    end
  endfunction

  // Walks the bisection tree for one search box and queues the answer words.
  task automatic predict_query(input req_word_t w);
    int        a, b, s, e, n;
    bit        box_empty, have_held;
    coord_t    ex0, ex1, ey0, ey1;
    seg_word_t held;
    n = 0;
    have_held = 1'b0;
    held = '0;
    box_empty = (w.qx0 > w.qx1) || (w.qy0 > w.qy1);
    s = chain_start_q;
    e = chain_end_q;
    range_level = 0;
    if (s < e)
      push_range(s, e);
    while (range_level > 0 && n < ResCap) begin
      range_level--;
      a = range_lo[range_level];
      b = range_hi[range_level];
      if (a >= b)
        continue;
      // A single segment is selected without looking at the box at all.
      if (b - a == 1) begin
        if (have_held)
          expected_segs.push_back(held);
        held.seg = a[IdxW-1:0];
        held.vld = 1'b1;
        held.lst = 1'b0;
        have_held = 1'b1;
        n++;
        continue;
      end
      if (box_empty)
        continue;
      ex0 = (pt_x[a] < pt_x[b]) ? pt_x[a] : pt_x[b];
      ex1 = (pt_x[a] > pt_x[b]) ? pt_x[a] : pt_x[b];
      ey0 = (pt_y[a] < pt_y[b]) ? pt_y[a] : pt_y[b];
      ey1 = (pt_y[a] > pt_y[b]) ? pt_y[a] : pt_y[b];
      // Edges that meet still count as touching.
      if (w.qx0 > ex1 || w.qx1 < ex0 || w.qy0 > ey1 || w.qy1 < ey0)
        continue;
      push_range((a + b) / 2, b);
      push_range(a, (a + b) / 2);
    end
    range_level = 0;
    if (n == 0) begin
      held.seg = '0;
      held.vld = 1'b0;
      held.lst = 1'b1;
      n = 1;
    end else begin
      held.lst = 1'b1;
    end
    expected_segs.push_back(held);
    if (n > longest_answer)
      longest_answer = n;
  endtask

  // ---------------------------------------------------------------------------
  // Input side. Words change on the falling edge; a word stays up until the
  // rising edge that takes it, and then a fresh random gap is waited out
  // before the next word, unless the current phase runs flat out.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || word_taken) begin
      word_taken = 1'b0;
      if (send_gap > 0) begin
        s_axis_tvalid <= 1'b0;
        send_gap--;
      end else if (pending_words.size() > 0) begin
        cur_word = pending_words.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cur_word.kind;
        s_axis_tdata  <= {{PadW{1'b0}}, cur_word.qy1, cur_word.qy0, cur_word.qx1,
                          cur_word.qx0, cur_word.py, cur_word.px, cur_word.slot};
        send_gap = no_gaps ? 0 : $urandom_range(0, 19);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // An accepted word updates the predictor at once: a load writes the store,
  // a query queues its whole answer.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      if (cur_word.kind == REQ_QUERY) begin
        predict_query(cur_word);
      end else begin
        pt_x[cur_word.slot] = cur_word.px;
        pt_y[cur_word.slot] = cur_word.py;
      end
      word_taken = 1'b1;
      words_left--;
    end
  end

  // ---------------------------------------------------------------------------
  // Output side. The receiver stalls for a random gap before each word; the
  // stall count runs whether or not the block has anything to offer, so the
  // stalls land on the walk as well as on the output register.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (seg_taken) begin
      seg_taken = 1'b0;
      ready_gap = no_gaps ? 0 : $urandom_range(0, 19);
    end
    if (ready_gap > 0) begin
      m_axis_tready <= 1'b0;
      ready_gap--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seg_taken = 1'b1;
      results_seen++;
      if (expected_segs.size() == 0) begin
        flag_mismatch("result word with nothing expected", m_axis_tdata[IdxW-1:0], -1);
      end else begin
        want_seg = expected_segs.pop_front();
        if (m_axis_tdata[IdxW-1:0] !== want_seg.seg)
          flag_mismatch("segment_index", m_axis_tdata[IdxW-1:0], want_seg.seg);
        if (m_axis_tuser !== want_seg.vld)
          flag_mismatch("segment_valid", m_axis_tuser, want_seg.vld);
        if (m_axis_tlast !== want_seg.lst)
          flag_mismatch("last", m_axis_tlast, want_seg.lst);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  function automatic coord_t clamp_coord(input longint v);
    if (v > longint'(CoordMax))
      return CoordMax;
    if (v < longint'(CoordMin))
      return CoordMin;
    return coord_t'(v);
  endfunction

  task automatic push_load(input int slot, input coord_t x, input coord_t y);
    req_word_t w;
    w.kind = REQ_LOAD;
    w.slot = slot[IdxW-1:0];
    w.px   = x;
    w.py   = y;
    // The box fields mean nothing on a load; random bits keep them busy.
    w.qx0  = $urandom();
    w.qx1  = $urandom();
    w.qy0  = $urandom();
    w.qy1  = $urandom();
    gen_x[slot] = x;
    gen_y[slot] = y;
    gen_written[slot] = 1'b1;
    pending_words.push_back(w);
    words_left++;
    words_queued++;
    loads_sent++;
  endtask

  task automatic push_query(input coord_t x0, input coord_t x1,
                            input coord_t y0, input coord_t y1);
    req_word_t w;
    w.kind = REQ_QUERY;
    w.slot = $urandom_range(0, DefMaxPoints - 1);
    w.px   = $urandom();
    w.py   = $urandom();
    w.qx0  = x0;
    w.qx1  = x1;
    w.qy0  = y0;
    w.qy1  = y1;
    pending_words.push_back(w);
    words_left++;
    words_queued++;
    queries_sent++;
  endtask

  // Waits until every word is in and every answer is out, then a little more
  // so that a trailing load has certainly settled in the store.
  task automatic wait_drained();
    while (words_left != 0 || expected_segs.size() != 0)
      @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_chain(input int cs, input int ce);
    wait_drained();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_CHAIN_START;
    cfg_data_i <= cs[CfgDW-1:0];
    @(negedge clk_i);
    cfg_idx_i  <= REG_CHAIN_END;
    cfg_data_i <= ce[CfgDW-1:0];
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    chain_start_q = cs[IdxW-1:0];
    chain_end_q   = ce[IdxW-1:0];
    gen_cs = cs;
    gen_ce = ce;
    chain_settings++;
  endtask

  // Loads a fresh monotone chain over the slots cs to ce: x never falls and
  // y moves one way only, with steps either tiny or large.
  task automatic load_chain(input int cs, input int ce);
    longint x, y, dx, dy;
    int     i, dir;
    x   = longint'($urandom_range(0, 32'h7FFF_FFFF)) - 64'sh4000_0000;
    y   = longint'($urandom_range(0, 32'h7FFF_FFFF)) - 64'sh4000_0000;
    dx  = $urandom_range(0, 1) ? $urandom_range(0, 16) : $urandom_range(1, 1 << 23);
    dy  = $urandom_range(0, 1) ? $urandom_range(0, 16) : $urandom_range(1, 1 << 23);
    dir = $urandom_range(0, 1) ? 1 : -1;
    for (i = cs; i <= ce; i++) begin
      push_load(i, clamp_coord(x), clamp_coord(y));
      x = x + dx + $urandom_range(0, dx);
      y = y + dir * (dy + $urandom_range(0, dy));
    end
  endtask

  // Most boxes are cut around points of the loaded chain so that the walk
  // prunes at every depth; the rest are exact points, the whole plane,
  // inverted boxes and plain noise.
  task automatic push_random_query();
    int     kind, i, j;
    longint mx, my, lo_x, hi_x, lo_y, hi_y;
    coord_t a, b;
    kind = $urandom_range(0, 19);
    i = 0;
    j = 0;
    if (gen_cs < gen_ce) begin
      i = $urandom_range(gen_cs, gen_ce);
      j = $urandom_range(gen_cs, gen_ce);
    end
    if (kind < 11) begin
      mx = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 1 << 20);
      my = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 1 << 20);
      lo_x = (gen_x[i] < gen_x[j]) ? gen_x[i] : gen_x[j];
      hi_x = (gen_x[i] > gen_x[j]) ? gen_x[i] : gen_x[j];
      lo_y = (gen_y[i] < gen_y[j]) ? gen_y[i] : gen_y[j];
      hi_y = (gen_y[i] > gen_y[j]) ? gen_y[i] : gen_y[j];
      push_query(clamp_coord(lo_x - mx), clamp_coord(hi_x + mx),
                 clamp_coord(lo_y - my), clamp_coord(hi_y + my));
    end else if (kind < 13) begin
      push_query(gen_x[i], gen_x[i], gen_y[i], gen_y[i]);
    end else if (kind < 14) begin
      push_query(CoordMin, CoordMax, CoordMin, CoordMax);
    end else if (kind < 16) begin
      a = $urandom();
      b = $urandom();
      if (a < b) begin
        a = a ^ b;
        b = a ^ b;
        a = a ^ b;
      end
      if ($urandom_range(0, 1))
        push_query(a, b, CoordMin, CoordMax);
      else
        push_query(CoordMin, CoordMax, a, b);
    end else begin
      push_query($urandom(), $urandom(), $urandom(), $urandom());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence: reset, a directed opening, then random phases, each phase
  // with its own chain setting written while the block is idle.
  // ---------------------------------------------------------------------------
  initial begin
    int phase_no, cs, ce, k, directed_words;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset values give a chain of one segment over slots 0 and 1, with the
    // points at the far corners of the coordinate range. A single segment is
    // selected even when the box is inverted.
    push_load(0, CoordMin, CoordMax);
    push_load(1, CoordMax, CoordMin);
    push_query(0, 0, 0, 0);
    push_query(Unit, 0, 0, 0);

    // A start equal to or past the end gives the empty answer.
    write_chain(5, 5);
    push_query(CoordMin, CoordMax, CoordMin, CoordMax);
    write_chain(9, 3);
    push_query(CoordMin, CoordMax, CoordMin, CoordMax);

    // A short falling staircase over slots 2 to 6.
    write_chain(2, 6);
    for (k = 0; k < 5; k++)
      push_load(2 + k, k * Unit, -k * Unit);
    push_query(CoordMin, CoordMax, CoordMin, CoordMax);
    push_query(2 * Unit, 2 * Unit, -2 * Unit, -2 * Unit);
    // Clear of the chain on x: nothing is selected.
    push_query(5 * Unit, 6 * Unit, CoordMin, CoordMax);
    // The box edge meets the last point exactly.
    push_query(4 * Unit, 9 * Unit, CoordMin, CoordMax);
    // Inverted on x, then on y: ranges longer than one segment miss.
    push_query(Unit, 0, CoordMin, CoordMax);
    push_query(CoordMin, CoordMax, 0, -Unit);
    directed_words = words_queued;

    phase_no = 0;
    while (words_queued - directed_words < NumRandomWords) begin
      case (phase_no)
        1: begin
          cs = 0;
          ce = DefMaxPoints - 1;
        end
        3: begin
          cs = DefMaxPoints - 1;
          ce = DefMaxPoints - 1;
        end
        5: begin
          cs = DefMaxPoints - 2;
          ce = DefMaxPoints - 1;
        end
        7: begin
          cs = $urandom_range(1, DefMaxPoints - 1);
          ce = $urandom_range(0, cs - 1);
        end
        default: begin
          cs = $urandom_range(0, DefMaxPoints - 2);
          ce = ($urandom_range(0, 7) == 0) ? cs : cs + $urandom_range(1, 7);
          if (ce > DefMaxPoints - 1)
            ce = DefMaxPoints - 1;
        end
      endcase
      // Each phase starts only once the previous answers are all in.
      write_chain(cs, ce);
      no_gaps = ($urandom_range(0, 3) == 0);
      if (cs < ce)
        load_chain(cs, ce);
      // The whole plane over the full chain selects every segment, which is
      // the longest answer the block can give.
      if (cs == 0 && ce == DefMaxPoints - 1)
        push_query(CoordMin, CoordMax, CoordMin, CoordMax);
      repeat ($urandom_range(3, 8)) begin
        if ($urandom_range(0, 5) == 0)
          push_load($urandom_range(0, DefMaxPoints - 1), $urandom(), $urandom());
        push_random_query();
      end
      phase_no++;
    end

    wait_drained();
    repeat (100) @(posedge clk_i);
    $display("Summary: %0d point loads and %0d queries over %0d chain settings.",
             loads_sent, queries_sent, chain_settings);
    $display("Summary: %0d result words checked, longest answer %0d words.",
             results_seen, longest_answer);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Guard against a hung handshake; far beyond the slowest legal run.
  initial begin
    #30000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
